>>> sv/dda_pkg.sv
`default_nettype none
package dda_pkg;

	// Field widths of the command and pixel channels.
	localparam int COORD_W = 7;
	localparam int PAINT_W = 32;
	localparam int ADDR_W = 10;
	localparam int CFG_W = 6;

	// Image limits, slope precision and longest run.
	localparam int MAX_COLUMNS = 32;
	localparam int MAX_ROWS = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAX_RESULTS = 64;

	// Register reset values.
	localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(32);
	localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(32);

	// Derived datapath widths.
	localparam int DIFF_W = COORD_W + 1;
	localparam int MAG_W = COORD_W;
	localparam int POS_W = COORD_W + 2;
	localparam int ACC_W = POS_W + FRAC_BITS;
	localparam int DVD_W = MAG_W + FRAC_BITS + 1;
	localparam int Q_W = FRAC_BITS + 2;
	localparam int INC_W = Q_W + 1;
	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int K_W = $clog2(MAX_RESULTS);

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_COLUMNS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SETUP,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic setup;
		logic emit;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic last;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

>>> sv/dda_cmd_if.sv
`default_nettype none
interface dda_cmd_if import dda_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic signed [PAINT_W-1:0] paint_value;

	modport source (
		output valid, start_x, start_y, end_x, end_y, paint_value,
		input ready
	);
	modport sink (
		input valid, start_x, start_y, end_x, end_y, paint_value,
		output ready
	);
endinterface
`default_nettype wire

>>> sv/dda_pix_if.sv
`default_nettype none
interface dda_pix_if import dda_pkg::*; ();
	logic valid;
	logic ready;
	logic [ADDR_W-1:0] pixel_address;
	logic signed [PAINT_W-1:0] pixel_data;
	logic write_enable;
	logic last_sample;

	modport source (
		output valid, pixel_address, pixel_data, write_enable, last_sample,
		input ready
	);
	modport sink (
		input valid, pixel_address, pixel_data, write_enable, last_sample,
		output ready
	);
endinterface
`default_nettype wire

>>> sv/dda_ctrl.sv
`default_nettype none
module dda_ctrl import dda_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	state_t state_q;
	state_t state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic div_done;

	assign div_done = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_done) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State register and divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	// A transfer in starts a fresh division.
	a_load_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIVIDE && div_cnt_q == '0))
		else $error("command transfer did not start the division");

	// The division runs for exactly its step count.
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && div_done) |=> (state_q == ST_SETUP))
		else $error("division did not end after its last step");

	// The final sample returns the controller to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.last) |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle after the last sample");

endmodule
`default_nettype wire

>>> sv/dda_datapath.sv
`default_nettype none
module dda_datapath import dda_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_status_t              status,
	input  wire logic [COORD_W-1:0] start_x,
	input  wire logic [COORD_W-1:0] start_y,
	input  wire logic [COORD_W-1:0] end_x,
	input  wire logic [COORD_W-1:0] end_y,
	input  wire logic [PAINT_W-1:0] paint_value,
	input  wire logic [CFG_W-1:0]   columns,
	input  wire logic [CFG_W-1:0]   rows,
	dda_pix_if.source               pix
);

	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam int PROD_W = CFG_W + POS_W;

	// Command decode, only used at load.
	logic [DIFF_W-1:0] dx;
	logic [DIFF_W-1:0] dy;
	logic [MAG_W-1:0] adx;
	logic [MAG_W-1:0] ady;
	logic x_major;
	logic [DIFF_W-1:0] major_d;
	logic [DIFF_W-1:0] minor_d;
	logic [MAG_W-1:0] span;
	logic [MAG_W-1:0] minor_mag;
	logic [COORD_W-1:0] major_s;
	logic [COORD_W-1:0] minor_s;

	// Per-command registers.
	logic x_major_q;
	logic minor_neg_q;
	logic span_zero_q;
	logic [MAG_W-1:0] den_q;
	logic [MAG_W-1:0] rem_q;
	logic [DVD_W-1:0] div_q;
	logic [POS_W-1:0] step_q;
	logic [POS_W-1:0] major_q;
	logic [ACC_W-1:0] acc_q;
	logic [INC_W-1:0] inc_q;
	logic [K_W-1:0] k_q;
	logic [K_W-1:0] last_k_q;
	logic [PAINT_W-1:0] paint_q;

	// Output register.
	logic out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PAINT_W-1:0] data_q;
	logic we_q;
	logic last_q;

	always_comb begin
		dx = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
		dy = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
		adx = dx[DIFF_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
		ady = dy[DIFF_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
		x_major = (adx > ady);
		major_d = x_major ? dx : dy;
		minor_d = x_major ? dy : dx;
		span = x_major ? adx : ady;
		minor_mag = x_major ? ady : adx;
		major_s = x_major ? start_x : start_y;
		minor_s = x_major ? start_y : start_x;
	end

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	logic [MAG_W:0] trial;
	logic trial_fits;
	logic [MAG_W:0] trial_diff;

	always_comb begin
		trial = {rem_q, div_q[DVD_W-1]};
		trial_fits = (trial >= {1'b0, den_q});
		trial_diff = trial - {1'b0, den_q};
	end

	// The quotient carries one extra fraction bit; add one and halve to round.
	logic [Q_W:0] q_round;
	logic [Q_W-1:0] inc_mag;
	logic [INC_W-1:0] inc_d;

	always_comb begin
		q_round = {1'b0, div_q[Q_W-1:0]} + (Q_W+1)'(1);
		inc_mag = q_round[Q_W:1];
		if (span_zero_q) begin
			inc_d = '0;
		end else if (minor_neg_q) begin
			inc_d = -{1'b0, inc_mag};
		end else begin
			inc_d = {1'b0, inc_mag};
		end
	end

	// Current sample: round the minor position half away from zero, then bound it.
	logic acc_neg;
	logic [ACC_W-1:0] acc_mag;
	logic [ACC_W-1:0] rnd_sum;
	logic [POS_W-1:0] rnd_mag;
	logic [POS_W-1:0] minor_pos;
	logic [POS_W-1:0] px;
	logic [POS_W-1:0] py;
	logic in_bounds;
	logic [PROD_W-1:0] addr_full;

	always_comb begin
		acc_neg = acc_q[ACC_W-1];
		acc_mag = acc_neg ? -acc_q : acc_q;
		rnd_sum = acc_mag + ROUND_HALF;
		rnd_mag = rnd_sum[ACC_W-1:FRAC_BITS];
		minor_pos = acc_neg ? -rnd_mag : rnd_mag;
		px = x_major_q ? major_q : minor_pos;
		py = x_major_q ? minor_pos : major_q;
		in_bounds = !px[POS_W-1] && (px < POS_W'(columns))
			&& !py[POS_W-1] && (py < POS_W'(rows));
		addr_full = PROD_W'(columns) * PROD_W'(py) + PROD_W'(px);
	end

	assign status.last = (k_q == last_k_q);
	assign status.out_free = !out_valid_q || pix.ready;

	// Command registers, division and walk.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_major_q <= x_major;
			minor_neg_q <= minor_d[DIFF_W-1];
			span_zero_q <= (span == '0);
			den_q <= span;
			rem_q <= '0;
			div_q <= {minor_mag, {(DVD_W-MAG_W){1'b0}}};
			if (major_d == '0) begin
				step_q <= '0;
			end else if (major_d[DIFF_W-1]) begin
				step_q <= '1;
			end else begin
				step_q <= POS_W'(1);
			end
			major_q <= {{(POS_W-COORD_W){major_s[COORD_W-1]}}, major_s};
			acc_q <= {{(POS_W-COORD_W){minor_s[COORD_W-1]}}, minor_s,
				{FRAC_BITS{1'b0}}};
			last_k_q <= (span > MAG_W'(MAX_RESULTS - 1)) ? K_W'(MAX_RESULTS - 1)
				: span[K_W-1:0];
			paint_q <= paint_value;
		end
		if (cmd.div_step) begin
			rem_q <= trial_fits ? trial_diff[MAG_W-1:0] : trial[MAG_W-1:0];
			div_q <= {div_q[DVD_W-2:0], trial_fits};
		end
		if (cmd.setup) begin
			inc_q <= inc_d;
			k_q <= '0;
		end
		if (cmd.emit) begin
			acc_q <= acc_q + {{(ACC_W-INC_W){inc_q[INC_W-1]}}, inc_q};
			major_q <= major_q + step_q;
			k_q <= k_q + K_W'(1);
		end
	end

	// Output register: loaded on each sample, freed by a transfer out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			addr_q <= in_bounds ? addr_full[ADDR_W-1:0] : '0;
			data_q <= paint_q;
			we_q <= in_bounds;
			last_q <= status.last;
		end
	end

	assign pix.valid = out_valid_q;
	assign pix.pixel_address = addr_q;
	assign pix.pixel_data = data_q;
	assign pix.write_enable = we_q;
	assign pix.last_sample = last_q;

	// Samples outside the image carry a zero address.
	a_oob_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !we_q) |-> (addr_q == '0))
		else $error("out-of-bounds sample with nonzero address");

	// A new sample is never dropped: the output holds valid after loading.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("sample loaded without output valid");

	// A waiting sample holds still until it is taken.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pix.ready) |=>
			(out_valid_q && $stable({addr_q, data_q, we_q, last_q})))
		else $error("waiting sample changed before its transfer");

endmodule
`default_nettype wire

>>> sv/dda_line_rasterizer.sv
// Operation: a command transfer starts the serial slope division (ST_DIVIDE), then
// a setup state (ST_SETUP); the samples are then walked out in ST_EMIT.
// Throughput: one sample per cycle while the output is taken; a command yields N samples
// (N = min(major span + 1, 64)); no new command is taken until its last sample is emitted.
// The serial divider and the single sample walker set this timing.
// Reset (arst_n low) idles the controller, empties the output and sets both sizes to 32.
`default_nettype none
module dda_line_rasterizer import dda_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	dda_cmd_if.sink                 cmd,
	dda_pix_if.source               pix
);

	logic [CFG_W-1:0] columns_q;
	logic [CFG_W-1:0] rows_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_write;
	logic [CFG_W-1:0] columns_eff;
	logic [CFG_W-1:0] rows_eff;
	dp_cmd_t dp_cmd;
	dp_status_t dp_status;
	logic in_ready;

	// Configuration registers.
	assign pready = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_COLUMNS: columns_q <= pwdata[CFG_W-1:0];
				REG_ROWS: rows_q <= pwdata[CFG_W-1:0];
				default: columns_q <= columns_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COLUMNS: prdata = PDATA_W'(columns_q);
			REG_ROWS: prdata = PDATA_W'(rows_q);
			default: prdata = '0;
		endcase
	end

	// Sizes beyond the image limits are clamped.
	assign columns_eff = (columns_q > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : columns_q;
	assign rows_eff = (rows_q > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_q;

	assign cmd.ready = in_ready;

	dda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	dda_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.status      (dp_status),
		.start_x     (cmd.start_x),
		.start_y     (cmd.start_y),
		.end_x       (cmd.end_x),
		.end_y       (cmd.end_y),
		.paint_value (cmd.paint_value),
		.columns     (columns_eff),
		.rows        (rows_eff),
		.pix         (pix)
	);

endmodule
`default_nettype wire
